@@ rtl/core/lob_pkg.sv @@
// shared types and constants for the limit order book
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_MODIFY  = 2'd1;
  localparam logic [1:0] OP_CANCEL  = 2'd2;
  localparam logic [1:0] OP_EXECUTE = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam int ENTRY_W = 1 + 32 + 32 + 31;

  typedef struct packed {
    logic [1:0]  op;
    logic        side;
    logic [31:0] order_ref;
    logic [31:0] price_ticks;
    logic [30:0] quantity;
  } lob_req_t;

  typedef struct packed {
    logic [31:0] best_bid_price;
    logic [31:0] best_bid_volume;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_volume;
    logic        id_found;
    logic        table_full;
  } lob_rsp_t;

  typedef struct packed {
    logic        side;
    logic [31:0] id;
    logic [31:0] price;
    logic [30:0] quantity;
  } lob_entry_t;

endpackage
`default_nettype wire

@@ rtl/core/limit_order_book_top.sv @@
// limit order book top level: table, valid bits and scan sequencer
//
// Requests arrive on the in channel (in_valid / in_stall); each carries an
// add, modify, cancel or execute message. One result per request leaves on
// the out channel (out_valid / out_stall) with best bid, best ask, their
// level volumes and the found / full flags.
// Each request walks the order table one slot a cycle through the single
// read port of the entry ram: a locate pass (not for add), an insert pass
// (add and modify), a write-back step, then a best-bid and a best-ask pass
// and a hand-off step that loads the result register.
// in_stall is high while a request is in work, so no new request is taken
// until the result of the current one has been loaded.
// The result sits in an output register; the next request is taken while
// it waits, but the next result is not loaded until the receiver takes it.
// Reset clears out_valid and the valid bits of every slot at once (table
// empty); entry contents are left as they are and are never read unless valid.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_top
  import lob_pkg::*;
#(
  parameter int MAX_ORDERS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire lob_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lob_rsp_t      out_data
);
  localparam int AW = $clog2(MAX_ORDERS);
  localparam logic [AW:0] LAST = (AW+1)'(MAX_ORDERS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOCATE, S_INSERT, S_BEST, S_WRITE, S_OUT
  } state_t;

  state_t          state;
  lob_req_t        req;
  logic [MAX_ORDERS-1:0] valid_bits;
  logic [AW:0]     cnt;      // address issued
  logic            rd_live;  // read data of previous address present
  logic [AW-1:0]   rd_idx;
  logic            best_side;

  // per-pass scan registers
  logic            hit;
  logic [AW-1:0]   hit_idx;
  logic [31:0]     hit_price;
  logic [30:0]     hit_qty;
  logic            free_any;
  logic [AW-1:0]   free_idx;
  logic            match_any;
  logic [AW-1:0]   match_idx;
  logic            lvl_any;
  logic [31:0]     lvl_price;
  logic [31:0]     lvl_sum;
  logic            found;
  logic            full;
  logic [31:0]     bid_price;
  logic [31:0]     bid_volume;

  // ram ports
  logic            we;
  logic [AW-1:0]   waddr;
  lob_entry_t      wdata;
  lob_entry_t      rdata;

  lob_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ORDERS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt[AW-1:0]),
    .rdata(rdata)
  );

  // shared compare unit: better price on the scanned side
  logic better;
  logic cur_side;
  logic [31:0] cmp_ref;
  always_comb begin
    cur_side = (state == S_BEST) ? best_side : req.side;
    cmp_ref  = (state == S_BEST) ? lvl_price : hit_price;
    better   = (cur_side == SIDE_BUY) ? (rdata.price > cmp_ref)
                                      : (rdata.price < cmp_ref);
  end

  logic slot_ok;
  assign slot_ok = rd_live && valid_bits[rd_idx];

  // saturating level sum
  logic [32:0] sum_wide;
  logic [31:0] sum_sat;
  always_comb begin
    sum_wide = {1'b0, lvl_sum} + {2'b00, rdata.quantity};
    sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
  end

  logic scan_end;
  assign scan_end = !rd_live && (cnt > LAST);

  assign in_stall = (state != S_IDLE);

  // result register loads once the previous result has left
  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // sequencer, scan registers and table writes
  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      rd_live    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_live   <= 1'b0;
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req       <= in_data;
            cnt       <= '0;
            hit       <= 1'b0;
            free_any  <= 1'b0;
            match_any <= 1'b0;
            found     <= 1'b0;
            full      <= 1'b0;
            state     <= (in_data.op == OP_ADD) ? S_INSERT : S_LOCATE;
          end
        end
        S_LOCATE, S_INSERT, S_BEST: begin
          if (cnt <= LAST) begin
            rd_live <= 1'b1;
            rd_idx  <= cnt[AW-1:0];
            cnt     <= cnt + 1'b1;
          end
          // consume the read data of the previous address
          if (slot_ok) begin
            if (state == S_LOCATE) begin
              if (rdata.side == req.side && rdata.id == req.order_ref &&
                  (!hit || better)) begin
                hit       <= 1'b1;
                hit_idx   <= rd_idx;
                hit_price <= rdata.price;
                hit_qty   <= rdata.quantity;
              end
            end else if (state == S_INSERT) begin
              if (!match_any && rdata.side == req.side &&
                  rdata.id == req.order_ref && rdata.price == req.price_ticks) begin
                match_any <= 1'b1;
                match_idx <= rd_idx;
              end
            end else if (rdata.side == best_side) begin
              if (!lvl_any || better) begin
                lvl_any   <= 1'b1;
                lvl_price <= rdata.price;
                lvl_sum   <= {1'b0, rdata.quantity};
              end else if (rdata.price == lvl_price) begin
                lvl_sum <= sum_sat;
              end
            end
          end else if (rd_live && state == S_INSERT && !free_any) begin
            free_any <= 1'b1;
            free_idx <= rd_idx;
          end
          if (scan_end) begin
            cnt <= '0;
            if (state == S_LOCATE) begin
              found <= hit;
              if (hit && (req.op != OP_EXECUTE ||
                          {1'b0, req.quantity} >= {1'b0, hit_qty})) begin
                valid_bits[hit_idx] <= 1'b0;
                // freed slot may be reused by the add half of modify
                if (req.op == OP_MODIFY) begin
                  free_any <= 1'b0;
                end
              end else if (hit && req.op == OP_EXECUTE) begin
                we    <= 1'b1;
                waddr <= hit_idx;
                wdata <= '{side: req.side, id: req.order_ref, price: hit_price,
                           quantity: hit_qty - req.quantity};
              end
              state <= (req.op == OP_MODIFY) ? S_INSERT : S_WRITE;
            end else if (state == S_INSERT) begin
              state <= S_WRITE;
              if (match_any) begin
                we    <= 1'b1;
                waddr <= match_idx;
                wdata <= '{side: req.side, id: req.order_ref,
                           price: req.price_ticks, quantity: req.quantity};
              end else if (free_any) begin
                we    <= 1'b1;
                waddr <= free_idx;
                wdata <= '{side: req.side, id: req.order_ref,
                           price: req.price_ticks, quantity: req.quantity};
                valid_bits[free_idx] <= 1'b1;
              end else begin
                full <= 1'b1;
              end
            end else if (best_side == SIDE_BUY) begin
              bid_price  <= lvl_any ? lvl_price : 32'd0;
              bid_volume <= lvl_any ? lvl_sum : 32'd0;
              best_side  <= SIDE_SELL;
              lvl_any    <= 1'b0;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_WRITE: begin
          // write lands before the best-price passes start reading
          best_side <= SIDE_BUY;
          lvl_any   <= 1'b0;
          cnt       <= '0;
          state     <= S_BEST;
        end
        S_OUT: begin
          // ask level is still held in the level registers
          if (out_load) begin
            out_data <= '{best_bid_price: bid_price, best_bid_volume: bid_volume,
                          best_ask_price: lvl_any ? lvl_price : 32'd0,
                          best_ask_volume: lvl_any ? lvl_sum : 32'd0,
                          id_found: found, table_full: full};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // no request taken while one is in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("request accepted while busy");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");
  // a found id on modify frees a slot, so found and full never meet
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.id_found && out_data.table_full))
    else $error("found and full flags both set");
  // finished request waits while the previous result is stalled
  a_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("result loaded over a waiting one");
`endif
endmodule
`default_nettype wire

@@ rtl/core/lob_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ tb/sv/limit_order_book_top_tb.sv @@
// self-checking testbench for the limit order book top level
`timescale 1ns / 1ps
module limit_order_book_top_tb;
  import lob_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lob_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lob_rsp_t out_data;

  limit_order_book_top #(.MAX_ORDERS(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // book shadow
  logic        bk_valid [DEPTH];
  logic        bk_side  [DEPTH];
  logic [31:0] bk_id    [DEPTH];
  logic [31:0] bk_price [DEPTH];
  logic [30:0] bk_qty   [DEPTH];

  lob_req_t pending_reqs[$];
  lob_rsp_t book_snapshots[$];
  int  errors = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int find_order(logic sd, logic [31:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_valid[i] || bk_side[i] != sd || bk_id[i] != id) continue;
      if (hit < 0 || (sd == SIDE_BUY && bk_price[i] > bk_price[hit]) ||
          (sd == SIDE_SELL && bk_price[i] < bk_price[hit]))
        hit = i;
    end
    return hit;
  endfunction

  // returns 1 when no slot was free and no entry matched
  function automatic bit place_order(logic sd, logic [31:0] id, logic [31:0] px,
                                     logic [30:0] qty);
    int free_slot;
    free_slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (bk_valid[i]) begin
        if (bk_side[i] == sd && bk_id[i] == id && bk_price[i] == px) begin
          bk_qty[i] = qty;
          return 1'b0;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot < 0) return 1'b1;
    bk_valid[free_slot] = 1'b1;
    bk_side[free_slot]  = sd;
    bk_id[free_slot]    = id;
    bk_price[free_slot] = px;
    bk_qty[free_slot]   = qty;
    return 1'b0;
  endfunction

  function automatic void top_of_side(logic sd, output logic [31:0] px,
                                      output logic [31:0] vol);
    bit any;
    logic [31:0] best;
    logic [32:0] sum;
    any = 1'b0;
    best = '0;
    sum = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_valid[i] || bk_side[i] != sd) continue;
      if (!any || (sd == SIDE_BUY && bk_price[i] > best) ||
          (sd == SIDE_SELL && bk_price[i] < best)) begin
        any = 1'b1;
        best = bk_price[i];
        sum = '0;
      end
      if (bk_price[i] == best) begin
        sum = sum + bk_qty[i];
        if (sum > 33'hFFFF_FFFF) sum = 33'hFFFF_FFFF;
      end
    end
    px = any ? best : '0;
    vol = any ? sum[31:0] : '0;
  endfunction

  function automatic lob_rsp_t apply_message(lob_req_t r);
    lob_rsp_t s;
    int slot;
    s = '0;
    if (r.op == OP_ADD) begin
      s.table_full = place_order(r.side, r.order_ref, r.price_ticks, r.quantity);
    end else begin
      slot = find_order(r.side, r.order_ref);
      s.id_found = slot >= 0;
      if (r.op == OP_MODIFY || r.op == OP_CANCEL) begin
        if (slot >= 0) bk_valid[slot] = 1'b0;
        if (r.op == OP_MODIFY)
          s.table_full = place_order(r.side, r.order_ref, r.price_ticks, r.quantity);
      end else if (slot >= 0) begin
        if (r.quantity >= bk_qty[slot]) bk_valid[slot] = 1'b0;
        else bk_qty[slot] = bk_qty[slot] - r.quantity;
      end
    end
    top_of_side(SIDE_BUY, s.best_bid_price, s.best_bid_volume);
    top_of_side(SIDE_SELL, s.best_ask_price, s.best_ask_volume);
    return s;
  endfunction

  function automatic lob_req_t mk(logic [1:0] op, logic sd, logic [31:0] id,
                                  logic [31:0] px, logic [30:0] qty);
    lob_req_t r;
    r.op = op; r.side = sd; r.order_ref = id; r.price_ticks = px; r.quantity = qty;
    return r;
  endfunction

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        book_snapshots.push_back(apply_message(in_data));
        void'(pending_reqs.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 3))
        0: out_stall <= 1'b1;
        default: out_stall <= ($urandom_range(0, 15) == 0) ? 1'b1 : 1'b0;
      endcase
    end
  end

  initial begin
    #1;
    wait (!rst);
    repeat (2000) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    lob_rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (book_snapshots.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = book_snapshots.pop_front();
        if (out_data.best_bid_price !== e.best_bid_price) begin
          $error("best_bid_price exp %h got %h", e.best_bid_price, out_data.best_bid_price);
          errors++;
        end
        if (out_data.best_bid_volume !== e.best_bid_volume) begin
          $error("best_bid_volume exp %h got %h", e.best_bid_volume,
                 out_data.best_bid_volume);
          errors++;
        end
        if (out_data.best_ask_price !== e.best_ask_price) begin
          $error("best_ask_price exp %h got %h", e.best_ask_price, out_data.best_ask_price);
          errors++;
        end
        if (out_data.best_ask_volume !== e.best_ask_volume) begin
          $error("best_ask_volume exp %h got %h", e.best_ask_volume,
                 out_data.best_ask_volume);
          errors++;
        end
        if (out_data.id_found !== e.id_found) begin
          $error("id_found exp %b got %b", e.id_found, out_data.id_found);
          errors++;
        end
        if (out_data.table_full !== e.table_full) begin
          $error("table_full exp %b got %b", e.table_full, out_data.table_full);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic lob_req_t random_message();
    logic [1:0] op;
    logic [31:0] id, px;
    logic [30:0] qty;
    int k;
    op = 2'($urandom_range(0, 3));
    // narrow id and price pools so orders collide and levels stack
    id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15);
    k = $urandom_range(0, 9);
    px = (k == 0) ? $urandom : (k == 1) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
         : 32'd1000 + $urandom_range(0, 12);
    k = $urandom_range(0, 9);
    qty = 31'((k == 0) ? $urandom : (k == 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
          : (k == 2) ? 32'd0 : $urandom_range(1, 200));
    return mk(op, 1'($urandom_range(0, 1)), id, px, qty);
  endfunction

  // stimulus
  initial begin
    for (int i = 0; i < DEPTH; i++) bk_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, each op, overwrite, duplicate ids, not found, zero size
    pending_reqs.push_back(mk(OP_CANCEL, SIDE_BUY, 32'd5, 32'd0, 31'd1));
    pending_reqs.push_back(mk(OP_EXECUTE, SIDE_SELL, 32'd5, 32'd0, 31'd1));
    pending_reqs.push_back(mk(OP_ADD, SIDE_BUY, 32'd1, 32'd100, 31'd10));
    pending_reqs.push_back(mk(OP_ADD, SIDE_BUY, 32'd1, 32'd100, 31'd25));
    pending_reqs.push_back(mk(OP_ADD, SIDE_BUY, 32'd1, 32'd120, 31'd7));
    pending_reqs.push_back(mk(OP_ADD, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              31'h7FFF_FFFF));
    pending_reqs.push_back(mk(OP_ADD, SIDE_SELL, 32'd2, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    pending_reqs.push_back(mk(OP_ADD, SIDE_SELL, 32'd3, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    pending_reqs.push_back(mk(OP_ADD, SIDE_BUY, 32'd0, 32'd0, 31'd0));
    pending_reqs.push_back(mk(OP_CANCEL, SIDE_BUY, 32'd1, 32'd0, 31'd0));
    pending_reqs.push_back(mk(OP_EXECUTE, SIDE_BUY, 32'd1, 32'd0, 31'd5));
    pending_reqs.push_back(mk(OP_EXECUTE, SIDE_BUY, 32'd1, 32'd0, 31'h7FFF_FFFF));
    pending_reqs.push_back(mk(OP_MODIFY, SIDE_SELL, 32'd2, 32'd50, 31'd3));
    pending_reqs.push_back(mk(OP_MODIFY, SIDE_SELL, 32'd77, 32'd40, 31'd9));
    pending_reqs.push_back(mk(OP_EXECUTE, SIDE_SELL, 32'hFFFF_FFFF, 32'd0, 31'd0));
    // fill the table, then overflow with an add and a modify
    for (int i = 0; i < DEPTH; i++)
      pending_reqs.push_back(mk(OP_ADD, i[0], 32'd1000 + i, 32'd500 + i, 31'd1));
    pending_reqs.push_back(mk(OP_ADD, SIDE_BUY, 32'd9999, 32'd1, 31'd1));
    pending_reqs.push_back(mk(OP_MODIFY, SIDE_BUY, 32'd4242, 32'd2, 31'd1));
    pending_reqs.push_back(mk(OP_MODIFY, SIDE_BUY, 32'd1000, 32'd3, 31'd4));
    for (int i = 0; i < DEPTH; i++)
      pending_reqs.push_back(mk(OP_CANCEL, i[0], 32'd1000 + i, 32'd0, 31'd0));
    // random part
    for (int i = 0; i < 760; i++) pending_reqs.push_back(random_message());
    wait (pending_reqs.size() == 0);
    wait (book_snapshots.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/lob_pkg.sv
rtl/core/lob_ram.sv
rtl/core/limit_order_book_top.sv
tb/sv/limit_order_book_top_tb.sv
